// File: design/ftzr_pkg.sv
// Package with shared types, widths and constants of the triangle raster unit.
package ftzr_pkg;

    // Default store geometry.
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    // Field and datapath widths.
    localparam int COLW  = 24;
    localparam int ZW    = 26;
    localparam int CFGW  = 9;
    localparam int CW    = 14;
    localparam int EW    = 38;

    // Register reset values and the empty depth marker.
    localparam logic [CFGW-1:0] CFG_RESET = 9'd256;
    localparam logic signed [ZW-1:0] DEPTH_BOTTOM = {1'b1, {(ZW-1){1'b0}}};

    // Configuration register indexes.
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // Item modes; the last code is unused and changes nothing.
    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_DRAW = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;
    localparam logic [1:0] MODE_NOP  = 2'd3;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CHECK,
        ST_SETUP,
        ST_SCAN,
        ST_DRAIN,
        ST_RDWAIT,
        ST_RESP
    } state_t;

endpackage

// File: design/ftzr_if.sv
// Channel interfaces for triangle items and for result items.
interface ftzr_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] bx;
    logic signed [15:0] by;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [23:0] za;
    logic signed [23:0] zb;
    logic signed [23:0] zc;
    logic [23:0]       color;

    modport source (output valid, mode, ax, ay, bx, by, cx, cy, za, zb, zc, color,
                    input ready);
    modport sink   (input valid, mode, ax, ay, bx, by, cx, cy, za, zb, zc, color,
                    output ready);
endinterface

interface ftzr_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] pixel_color;
    logic        skipped;

    modport source (output valid, pixel_color, skipped, input ready);
    modport sink   (input valid, pixel_color, skipped, output ready);
endinterface

// File: design/flat_triangle_zbuffer_raster_unit.sv
// Top level of the flat shaded z-buffer triangle raster unit.
// The unit takes one item at a time; a drawn triangle is scanned over its bounding box,
// one pixel a cycle through the depth memory read-modify-write loop. A new item is taken
// only in the idle state, entered as the previous result enters the output register.
// Reset clears control state and sets both size registers to 256; the memories keep no reset
// and must be loaded before use.
module flat_triangle_zbuffer_raster_unit #(
    parameter int MAX_WIDTH  = ftzr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ftzr_pkg::DEF_MAX_HEIGHT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic                       cfg_index,
    input  logic [ftzr_pkg::CFGW-1:0]  cfg_data,
    ftzr_in_if.sink                    item_in,
    ftzr_out_if.source                 result_out
);

    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int AW = XW + YW;
    localparam int CW = ftzr_pkg::CW;
    localparam int EW = ftzr_pkg::EW;
    localparam int ZW = ftzr_pkg::ZW;

    ftzr_pkg::state_t state_reg, state_next;

    logic [ftzr_pkg::CFGW-1:0] width_reg, height_reg;
    logic [1:0]               mode_reg;
    logic signed [15:0]       vx_reg [3];
    logic signed [15:0]       vy_reg [3];
    logic signed [ZW-1:0]     zsum_reg;
    logic [23:0]              color_reg;
    logic signed [CW-1:0]     xmin_reg, xmax_reg, ymin_reg, ymax_reg;
    logic signed [16:0]       dx_reg [3];
    logic signed [16:0]       dy_reg [3];
    logic signed [EW-1:0]     prod_reg;
    logic signed [EW-1:0]     l_reg [3];
    logic signed [EW-1:0]     lcol_reg [3];
    logic [2:0]               cnt_reg;
    logic [XW-1:0]            x_reg;
    logic [YW-1:0]            y_reg;
    logic                     wb_valid_reg;
    logic [AW-1:0]            wb_addr_reg;
    logic [23:0]              res_color_reg;
    logic                     res_skip_reg;
    logic                     out_valid_reg;
    logic [23:0]              out_color_reg;
    logic                     out_skip_reg;

    // Effective image size.
    logic [CW-1:0] eff_w, eff_h;
    assign eff_w = ({{(CW-ftzr_pkg::CFGW){1'b0}}, width_reg} < CW'(MAX_WIDTH)) ?
                   {{(CW-ftzr_pkg::CFGW){1'b0}}, width_reg} : CW'(MAX_WIDTH);
    assign eff_h = ({{(CW-ftzr_pkg::CFGW){1'b0}}, height_reg} < CW'(MAX_HEIGHT)) ?
                   {{(CW-ftzr_pkg::CFGW){1'b0}}, height_reg} : CW'(MAX_HEIGHT);

    // Pixel bounds check for load and read.
    logic signed [16:0] px17, py17;
    logic               pix_ok;
    assign px17   = {vx_reg[0][15], vx_reg[0]};
    assign py17   = {vy_reg[0][15], vy_reg[0]};
    assign pix_ok = !px17[16] && !py17[16] &&
                    (px17 < $signed({{(17-CW){1'b0}}, eff_w})) &&
                    (py17 < $signed({{(17-CW){1'b0}}, eff_h}));

    // Bounding box: ceiling of the minimum, floor of the maximum.
    logic signed [15:0] minx, maxx, miny, maxy, m0, m1;
    logic signed [16:0] minx_r, miny_r;
    always_comb
    begin
        m0   = (vx_reg[0] < vx_reg[1]) ? vx_reg[0] : vx_reg[1];
        minx = (m0 < vx_reg[2]) ? m0 : vx_reg[2];
        m1   = (vx_reg[0] > vx_reg[1]) ? vx_reg[0] : vx_reg[1];
        maxx = (m1 > vx_reg[2]) ? m1 : vx_reg[2];
        m0   = (vy_reg[0] < vy_reg[1]) ? vy_reg[0] : vy_reg[1];
        miny = (m0 < vy_reg[2]) ? m0 : vy_reg[2];
        m1   = (vy_reg[0] > vy_reg[1]) ? vy_reg[0] : vy_reg[1];
        maxy = (m1 > vy_reg[2]) ? m1 : vy_reg[2];
        minx_r = {minx[15], minx} + 17'sd15;
        miny_r = {miny[15], miny} + 17'sd15;
    end

    // Skip decision on the registered box.
    logic skip;
    assign skip = (xmax_reg < xmin_reg) || (ymax_reg < ymin_reg) ||
                  (xmax_reg >= $signed(eff_w)) || (ymax_reg >= $signed(eff_h)) ||
                  xmin_reg[CW-1] || ymin_reg[CW-1];

    // Offsets of the first box pixel from each vertex, in Q15.4.
    logic signed [18:0] ex [3];
    logic signed [18:0] ey [3];
    always_comb
    begin
        for (int v = 0; v < 3; v++)
        begin
            ex[v] = {xmin_reg[CW-1], xmin_reg, 4'b0} - {{3{vx_reg[v][15]}}, vx_reg[v]};
            ey[v] = {ymin_reg[CW-1], ymin_reg, 4'b0} - {{3{vy_reg[v][15]}}, vy_reg[v]};
        end
    end

    // Operand selection for the shared setup multiplier.
    logic signed [18:0] opa;
    logic signed [16:0] opb;
    always_comb
    begin
        case (cnt_reg)
            3'd0:    begin opa = ey[0]; opb = dx_reg[0]; end
            3'd1:    begin opa = ex[0]; opb = dy_reg[0]; end
            3'd2:    begin opa = ey[1]; opb = dx_reg[1]; end
            3'd3:    begin opa = ex[1]; opb = dy_reg[1]; end
            3'd4:    begin opa = ey[2]; opb = dx_reg[2]; end
            default: begin opa = ex[2]; opb = dy_reg[2]; end
        endcase
    end

    // Edge steps along a column and across columns.
    logic signed [EW-1:0] sy [3];
    logic signed [EW-1:0] sx [3];
    always_comb
    begin
        for (int e = 0; e < 3; e++)
        begin
            sy[e] = {{(EW-21){dx_reg[e][16]}}, dx_reg[e], 4'b0};
            sx[e] = -{{(EW-21){dy_reg[e][16]}}, dy_reg[e], 4'b0};
        end
    end

    // Coverage test: all edges strictly of one sign.
    logic all_pos, all_neg, covered;
    always_comb
    begin
        all_pos = 1'b1;
        all_neg = 1'b1;
        for (int e = 0; e < 3; e++)
        begin
            all_pos = all_pos && !l_reg[e][EW-1] && (l_reg[e] != '0);
            all_neg = all_neg && l_reg[e][EW-1];
        end
        covered = all_pos || all_neg;
    end

    logic scan_last, col_last;
    assign col_last  = (y_reg == ymax_reg[YW-1:0]);
    assign scan_last = col_last && (x_reg == xmax_reg[XW-1:0]);

    // Memory access.
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic signed [ZW-1:0] depth_wdata;
    logic [23:0]          color_rdata;
    logic signed [ZW-1:0] depth_rdata;
    logic [AW-1:0]        pix_addr;
    logic                 load_we;
    assign pix_addr = {vy_reg[0][YW-1:0], vx_reg[0][XW-1:0]};
    assign load_we  = (state_reg == ftzr_pkg::ST_DECODE) &&
                      (mode_reg == ftzr_pkg::MODE_LOAD) && pix_ok;
    assign mem_we      = load_we || (wb_valid_reg && (zsum_reg > depth_rdata));
    assign mem_waddr   = load_we ? pix_addr : wb_addr_reg;
    assign depth_wdata = load_we ? ftzr_pkg::DEPTH_BOTTOM : zsum_reg;

    ftzr_store #(
        .AW (AW)
    ) u_store (
        .clk         (clk),
        .we          (mem_we),
        .waddr       (mem_waddr),
        .color_wdata (color_reg),
        .depth_wdata (depth_wdata),
        .color_raddr (pix_addr),
        .color_rdata (color_rdata),
        .depth_raddr ({y_reg, x_reg}),
        .depth_rdata (depth_rdata)
    );

    logic out_free;
    assign out_free = !out_valid_reg || result_out.ready;

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ftzr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ftzr_pkg::ST_IDLE:
            begin
                if (item_in.valid)
                begin
                    state_next = ftzr_pkg::ST_DECODE;
                end
            end
            ftzr_pkg::ST_DECODE:
            begin
                case (mode_reg)
                    ftzr_pkg::MODE_DRAW: state_next = ftzr_pkg::ST_CHECK;
                    ftzr_pkg::MODE_READ:
                        state_next = pix_ok ? ftzr_pkg::ST_RDWAIT : ftzr_pkg::ST_RESP;
                    default:             state_next = ftzr_pkg::ST_RESP;
                endcase
            end
            ftzr_pkg::ST_CHECK:
            begin
                state_next = skip ? ftzr_pkg::ST_RESP : ftzr_pkg::ST_SETUP;
            end
            ftzr_pkg::ST_SETUP:
            begin
                if (cnt_reg == 3'd6)
                begin
                    state_next = ftzr_pkg::ST_SCAN;
                end
            end
            ftzr_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ftzr_pkg::ST_DRAIN;
                end
            end
            ftzr_pkg::ST_DRAIN:  state_next = ftzr_pkg::ST_RESP;
            ftzr_pkg::ST_RDWAIT: state_next = ftzr_pkg::ST_RESP;
            ftzr_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ftzr_pkg::ST_IDLE;
                end
            end
            default: state_next = ftzr_pkg::ST_IDLE;
        endcase
    end

    assign item_in.ready = (state_reg == ftzr_pkg::ST_IDLE);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= ftzr_pkg::CFG_RESET;
            height_reg <= ftzr_pkg::CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                ftzr_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                ftzr_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Control registers: write-back strobe, output valid and setup counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            wb_valid_reg <= (state_reg == ftzr_pkg::ST_SCAN) && covered;
            if (state_reg == ftzr_pkg::ST_RESP && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ftzr_pkg::ST_SETUP)
            begin
                cnt_reg <= cnt_reg + 3'd1;
            end
            else
            begin
                cnt_reg <= '0;
            end
        end
    end

    // Payload capture on an input transfer.
    always_ff @(posedge clk)
    begin
        if (item_in.valid && item_in.ready)
        begin
            mode_reg  <= item_in.mode;
            vx_reg[0] <= item_in.ax;
            vx_reg[1] <= item_in.bx;
            vx_reg[2] <= item_in.cx;
            vy_reg[0] <= item_in.ay;
            vy_reg[1] <= item_in.by;
            vy_reg[2] <= item_in.cy;
            zsum_reg  <= {{2{item_in.za[23]}}, item_in.za} +
                         {{2{item_in.zb[23]}}, item_in.zb} +
                         {{2{item_in.zc[23]}}, item_in.zc};
            color_reg <= item_in.color;
        end
    end

    // Box, setup and scan datapath.
    always_ff @(posedge clk)
    begin
        if (state_reg == ftzr_pkg::ST_DECODE)
        begin
            xmin_reg      <= CW'(minx_r >>> 4);
            ymin_reg      <= CW'(miny_r >>> 4);
            xmax_reg      <= CW'(maxx >>> 4);
            ymax_reg      <= CW'(maxy >>> 4);
            res_color_reg <= '0;
            res_skip_reg  <= 1'b0;
        end
        if (state_reg == ftzr_pkg::ST_CHECK)
        begin
            res_skip_reg <= skip;
            dx_reg[0] <= {vx_reg[1][15], vx_reg[1]} - {vx_reg[0][15], vx_reg[0]};
            dy_reg[0] <= {vy_reg[1][15], vy_reg[1]} - {vy_reg[0][15], vy_reg[0]};
            dx_reg[1] <= {vx_reg[2][15], vx_reg[2]} - {vx_reg[1][15], vx_reg[1]};
            dy_reg[1] <= {vy_reg[2][15], vy_reg[2]} - {vy_reg[1][15], vy_reg[1]};
            dx_reg[2] <= {vx_reg[0][15], vx_reg[0]} - {vx_reg[2][15], vx_reg[2]};
            dy_reg[2] <= {vy_reg[0][15], vy_reg[0]} - {vy_reg[2][15], vy_reg[2]};
        end
        if (state_reg == ftzr_pkg::ST_RDWAIT)
        begin
            res_color_reg <= color_rdata;
        end

        // Setup: one product a cycle, accumulated into the edge values.
        if (state_reg == ftzr_pkg::ST_SETUP)
        begin
            prod_reg <= EW'(opa * opb);
            case (cnt_reg)
                3'd1:    begin l_reg[0] <= prod_reg; lcol_reg[0] <= prod_reg; end
                3'd2:    begin
                             l_reg[0]    <= l_reg[0] - prod_reg;
                             lcol_reg[0] <= l_reg[0] - prod_reg;
                         end
                3'd3:    begin l_reg[1] <= prod_reg; lcol_reg[1] <= prod_reg; end
                3'd4:    begin
                             l_reg[1]    <= l_reg[1] - prod_reg;
                             lcol_reg[1] <= l_reg[1] - prod_reg;
                         end
                3'd5:    begin l_reg[2] <= prod_reg; lcol_reg[2] <= prod_reg; end
                3'd6:    begin
                             l_reg[2]    <= l_reg[2] - prod_reg;
                             lcol_reg[2] <= l_reg[2] - prod_reg;
                         end
                default: ;
            endcase
            x_reg <= xmin_reg[XW-1:0];
            y_reg <= ymin_reg[YW-1:0];
        end

        // Scan: down each column, then step to the next column.
        if (state_reg == ftzr_pkg::ST_SCAN)
        begin
            wb_addr_reg <= {y_reg, x_reg};
            if (col_last)
            begin
                x_reg <= x_reg + XW'(1);
                y_reg <= ymin_reg[YW-1:0];
                for (int e = 0; e < 3; e++)
                begin
                    lcol_reg[e] <= lcol_reg[e] + sx[e];
                    l_reg[e]    <= lcol_reg[e] + sx[e];
                end
            end
            else
            begin
                y_reg <= y_reg + YW'(1);
                for (int e = 0; e < 3; e++)
                begin
                    l_reg[e] <= l_reg[e] + sy[e];
                end
            end
        end

        // Output register.
        if (state_reg == ftzr_pkg::ST_RESP && out_free)
        begin
            out_color_reg <= res_color_reg;
            out_skip_reg  <= res_skip_reg;
        end
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.pixel_color = out_color_reg;
    assign result_out.skipped     = out_skip_reg;

endmodule

// File: design/ftzr_store.sv
// Colour and depth memories with one write port and registered read ports.
module ftzr_store #(
    parameter int AW = 16
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [AW-1:0]                     waddr,
    input  logic [ftzr_pkg::COLW-1:0]         color_wdata,
    input  logic signed [ftzr_pkg::ZW-1:0]    depth_wdata,
    input  logic [AW-1:0]                     color_raddr,
    output logic [ftzr_pkg::COLW-1:0]         color_rdata,
    input  logic [AW-1:0]                     depth_raddr,
    output logic signed [ftzr_pkg::ZW-1:0]    depth_rdata
);

    logic [ftzr_pkg::COLW-1:0]      color_mem [2**AW];
    logic signed [ftzr_pkg::ZW-1:0] depth_mem [2**AW];

    // Shared write, both stores take the same pixel.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            color_mem[waddr] <= color_wdata;
            depth_mem[waddr] <= depth_wdata;
        end
    end

    // Synchronous, registered reads.
    always_ff @(posedge clk)
    begin
        color_rdata <= color_mem[color_raddr];
        depth_rdata <= depth_mem[depth_raddr];
    end

endmodule
